// ===== hw/rtl/ucasv_pkg.sv =====
// Package for the circular-array steering vector generator.
// Holds the CORDIC arctangent table, fixed constants and shared types; depends on nothing.
package ucasv_pkg;

	localparam int MAX_CHANNELS_DEF = 16;
	localparam int ANGLE_BITS_DEF   = 16;
	localparam int SAMPLE_BITS_DEF  = 16;

	localparam int CORDIC_STEPS = 28;
	localparam int CW           = 34;
	localparam int ZW           = 32;
	localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	localparam int CNT_W = 5;
	localparam int RAD_W = 16;
	localparam logic [CNT_W-1:0] RESET_CHANNELS = 5'd9;
	localparam logic [RAD_W-1:0] RESET_RADIUS   = 16'd1352;

	localparam logic [0:0] REG_NUM_CHANNELS = 1'd0;
	localparam logic [0:0] REG_RING_RADIUS  = 1'd1;

	function automatic logic [ZW-1:0] atan_turn(input int i);
		logic [ZW-1:0] t;
		begin
			case (i)
				0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
				3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
				6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
				9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
				12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
				15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
				18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
				21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
				24: t = 32'd41;        25: t = 32'd20;        26: t = 32'd10;
				27: t = 32'd5;
				default: t = '0;
			endcase
			return t;
		end
	endfunction

	// Sideband that travels with a channel word through the pipeline.
	typedef struct packed {
		logic       vld;
		logic       refch;
		logic       last;
		logic [5:0] ch;
	} tag_t;

endpackage

// ===== hw/rtl/uca_steering_vector_generator.sv =====
// Steering vector generator for a uniform circular array: top level.
// Path: sequencer, first CORDIC, projection registers, second CORDIC, then the output registers.
// Throughput: one word per cycle, N words per azimuth for N channels (nine by default), set by
// the channel sequencer; busy holds off new azimuths and stays high after reset or a new count.
// Reset: asynchronous, active low; restores nine channels and a ring radius of 1352.
// The receiver cannot stall: each word is on the ports for exactly one cycle.
module uca_steering_vector_generator #(
	parameter int MAX_CHANNELS = ucasv_pkg::MAX_CHANNELS_DEF,
	parameter int ANGLE_BITS   = ucasv_pkg::ANGLE_BITS_DEF,
	parameter int SAMPLE_BITS  = ucasv_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [15:0]            azimuth,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [15:0]            cfg_data,
	output logic                   strobe,
	output logic [$clog2(MAX_CHANNELS)-1:0] channel,
	output logic signed [SAMPLE_BITS-1:0] phasor_re,
	output logic signed [SAMPLE_BITS-1:0] phasor_im,
	output logic                   last
);
	localparam int CW = ucasv_pkg::CW;
	localparam logic [31:0] AMASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

	// Configuration registers; writes land whenever offered.
	logic [4:0]  cnt_q;
	logic [15:0] rad_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= ucasv_pkg::RESET_CHANNELS;
			rad_q <= ucasv_pkg::RESET_RADIUS;
		end else if (cfg_valid) begin
			case (cfg_index)
				ucasv_pkg::REG_NUM_CHANNELS: cnt_q <= cfg_data[4:0];
				ucasv_pkg::REG_RING_RADIUS:  rad_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective channel count, clamped to one and to MAX_CHANNELS.
	logic [6:0] n_eff;
	always_comb begin
		if (cnt_q == 5'd0) n_eff = 7'd1;
		else if (7'(cnt_q) > 7'(MAX_CHANNELS)) n_eff = 7'(MAX_CHANNELS);
		else n_eff = 7'(cnt_q);
	end

	// Channel sequencer. The element angle (k-1)/(N-1) turn is kept as a running sum
	// of a 32-bit step plus a remainder, so no divider is needed per channel. The step
	// itself is found by a bit-serial divider only when N changes.
	logic        act_q;
	logic [6:0]  k_q, n_q;
	logic [31:0] theta_q, elem_q, step_q;
	logic [6:0]  rem_q, srem_q;

	// Serial divider for 2^32 / (N-1): recomputed after a change of N.
	logic [6:0]  dn_q;
	logic        dv_q;
	logic [5:0]  di_q;
	logic [31:0] dq_q;
	logic [7:0]  dr_q;
	logic [7:0]  dtr;
	logic [6:0]  dd;
	assign dd  = (n_eff > 7'd1) ? n_eff - 7'd1 : 7'd1;
	assign dtr = {dr_q[6:0], (di_q == 6'd0) ? 1'b1 : 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_q <= '0;
			dv_q <= 1'b0;
			di_q <= '0;
			dq_q <= '0;
			dr_q <= '0;
			step_q <= '0;
			srem_q <= '0;
		end else if (dn_q != n_eff) begin
			dn_q <= n_eff;
			dv_q <= 1'b0;
			di_q <= '0;
			dr_q <= '0;
			dq_q <= '0;
		end else if (!dv_q) begin
			// Long division of 2^32 over 33 dividend bits, MSB first.
			if (dtr >= {1'b0, dd}) begin
				dr_q <= dtr - {1'b0, dd};
				dq_q <= {dq_q[30:0], 1'b1};
			end else begin
				dr_q <= dtr;
				dq_q <= {dq_q[30:0], 1'b0};
			end
			if (di_q == 6'd32) begin
				dv_q <= 1'b1;
				step_q <= (dtr >= {1'b0, dd}) ? {dq_q[30:0], 1'b1} : {dq_q[30:0], 1'b0};
				srem_q <= (dtr >= {1'b0, dd}) ? 7'(dtr - {1'b0, dd}) : 7'(dtr);
			end
			di_q <= di_q + 6'd1;
		end
	end

	// The last channel of an azimuth leaves room for the next one in the same cycle.
	assign busy = (act_q && (k_q + 7'd1 < n_q)) || !dv_q || (dn_q != n_eff);

	logic [7:0]  rnext;
	logic [6:0]  ddq;
	assign ddq   = (n_q > 7'd1) ? n_q - 7'd1 : 7'd1;
	assign rnext = {1'b0, rem_q} + {1'b0, srem_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			k_q <= '0;
			n_q <= '0;
		end else if (start && !busy) begin
			act_q <= 1'b1;
			k_q <= '0;
			n_q <= n_eff;
		end else if (act_q) begin
			if (k_q + 7'd1 >= n_q) act_q <= 1'b0;
			k_q <= k_q + 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			theta_q <= (ucasv_pkg::QUARTER_TURN - {azimuth, 16'd0}) & AMASK;
			elem_q  <= '0;
			rem_q   <= '0;
		end else if (act_q && k_q != 7'd0) begin
			if (rnext >= {1'b0, ddq}) begin
				elem_q <= elem_q + step_q + 32'd1;
				rem_q  <= 7'(rnext - {1'b0, ddq});
			end else begin
				elem_q <= elem_q + step_q;
				rem_q  <= 7'(rnext);
			end
		end
	end

	// First CORDIC pass on theta minus element angle.
	ucasv_pkg::tag_t t0;
	logic [31:0]     diff;
	assign t0.vld   = act_q;
	assign t0.refch = (k_q == 7'd0);
	assign t0.last  = (k_q + 7'd1 >= n_q);
	assign t0.ch    = k_q[5:0];
	assign diff     = (theta_q - (elem_q & AMASK)) & AMASK;

	ucasv_pkg::tag_t        t1;
	logic signed [CW-1:0]   c1, s1;
	logic [15:0]            aux1;
	ucasv_cordic u_c1 (
		.clk(clk), .arst_n(arst_n), .tag_in(t0), .ang(diff), .aux_in(rad_q),
		.tag_out(t1), .cos_out(c1), .sin_out(s1), .aux_out(aux1)
	);

	// Projection on the radius, registered after the multiply.
	ucasv_pkg::tag_t      tp_s1, tp_s2;
	logic signed [CW+16:0] proj_s1;
	logic [31:0]          ph_s2;
	logic [32:0]          ph_r;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_s1 <= '0;
			tp_s2 <= '0;
		end else begin
			tp_s1 <= t1;
			tp_s2 <= tp_s1;
		end
	end
	logic signed [CW+16:0] psum;
	assign psum = proj_s1 + (CW+17)'(512);
	assign ph_r = {1'b0, psum[41:10]} + (33'd1 << (31 - ANGLE_BITS));
	always_ff @(posedge clk) begin
		proj_s1 <= c1 * $signed({1'b0, aux1});
		ph_s2   <= ph_r[31:0] & AMASK;
	end

	// Second CORDIC pass on the phase.
	ucasv_pkg::tag_t      t3;
	logic signed [CW-1:0] c3, s3;
	logic [15:0]          aux3;
	ucasv_cordic u_c2 (
		.clk(clk), .arst_n(arst_n), .tag_in(tp_s2), .ang(ph_s2), .aux_in(16'd0),
		.tag_out(t3), .cos_out(c3), .sin_out(s3), .aux_out(aux3)
	);

	// Rounding to Q1.(SAMPLE_BITS-1) with saturation.
	localparam logic signed [CW-1:0] HI = (CW'(1) <<< (SAMPLE_BITS - 1)) - CW'(1);
	localparam logic signed [CW-1:0] LO = -(CW'(1) <<< (SAMPLE_BITS - 1));
	function automatic logic [SAMPLE_BITS-1:0] to_s(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] r;
		begin
			r = (v + $signed(CW'(1) <<< (30 - SAMPLE_BITS))) >>> (31 - SAMPLE_BITS);
			if (r > HI) r = HI;
			if (r < LO) r = LO;
			return r[SAMPLE_BITS-1:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= t3.vld && (aux3 == 16'd0);
		end
	end

	always_ff @(posedge clk) begin
		channel <= t3.ch[$clog2(MAX_CHANNELS)-1:0];
		last    <= t3.last;
		if (t3.refch) begin
			phasor_re <= HI[SAMPLE_BITS-1:0];
			phasor_im <= '0;
		end else begin
			phasor_re <= to_s(c3);
			phasor_im <= to_s(s3);
		end
	end
endmodule

// ===== hw/rtl/ucasv_cordic_cell.sv =====
// One micro-rotation cell of the rotation-mode CORDIC chain.
// Depends on ucasv_pkg for widths, the arctangent table and the tag type.
module ucasv_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ucasv_pkg::tag_t                    tag_in,
	input  logic [1:0]                         quad_in,
	input  logic signed [ucasv_pkg::CW-1:0]    x_in,
	input  logic signed [ucasv_pkg::CW-1:0]    y_in,
	input  logic signed [ucasv_pkg::ZW:0]      z_in,
	input  logic [15:0]                        aux_in,
	output ucasv_pkg::tag_t                    tag_out,
	output logic [1:0]                         quad_out,
	output logic signed [ucasv_pkg::CW-1:0]    x_out,
	output logic signed [ucasv_pkg::CW-1:0]    y_out,
	output logic signed [ucasv_pkg::ZW:0]      z_out,
	output logic [15:0]                        aux_out
);
	logic signed [ucasv_pkg::CW-1:0] dx, dy;
	logic signed [ucasv_pkg::ZW:0]   at;

	assign dx = y_in >>> STEP;
	assign dy = x_in >>> STEP;
	assign at = $signed({1'b0, ucasv_pkg::atan_turn(STEP)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else begin
			tag_out <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		quad_out <= quad_in;
		aux_out  <= aux_in;
		if (!z_in[ucasv_pkg::ZW]) begin
			x_out <= x_in - dx;
			y_out <= y_in + dy;
			z_out <= z_in - at;
		end else begin
			x_out <= x_in + dx;
			y_out <= y_in - dy;
			z_out <= z_in + at;
		end
	end
endmodule

// ===== hw/rtl/ucasv_cordic.sv =====
// Full CORDIC: a chain of micro-rotation cells followed by quadrant fold-back.
// Depends on ucasv_pkg and ucasv_cordic_cell.
module ucasv_cordic (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ucasv_pkg::tag_t                 tag_in,
	input  logic [31:0]                     ang,
	input  logic [15:0]                     aux_in,
	output ucasv_pkg::tag_t                 tag_out,
	output logic signed [ucasv_pkg::CW-1:0] cos_out,
	output logic signed [ucasv_pkg::CW-1:0] sin_out,
	output logic [15:0]                     aux_out
);
	localparam int N = ucasv_pkg::CORDIC_STEPS;

	ucasv_pkg::tag_t                 tg [N+1];
	logic [1:0]                      qd [N+1];
	logic signed [ucasv_pkg::CW-1:0] xs [N+1];
	logic signed [ucasv_pkg::CW-1:0] ys [N+1];
	logic signed [ucasv_pkg::ZW:0]   zs [N+1];
	logic [15:0]                     ax [N+1];

	assign tg[0] = tag_in;
	assign qd[0] = ang[31:30];
	assign xs[0] = ucasv_pkg::CORDIC_START;
	assign ys[0] = '0;
	assign zs[0] = $signed({3'b000, ang[29:0]});
	assign ax[0] = aux_in;

	for (genvar i = 0; i < N; i++) begin : g_cell
		ucasv_cordic_cell #(.STEP(i)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.tag_in(tg[i]), .quad_in(qd[i]), .x_in(xs[i]), .y_in(ys[i]),
			.z_in(zs[i]), .aux_in(ax[i]),
			.tag_out(tg[i+1]), .quad_out(qd[i+1]), .x_out(xs[i+1]), .y_out(ys[i+1]),
			.z_out(zs[i+1]), .aux_out(ax[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else begin
			tag_out <= tg[N];
		end
	end

	always_ff @(posedge clk) begin
		aux_out <= ax[N];
		case (qd[N])
			2'd1: begin cos_out <= -ys[N]; sin_out <= xs[N]; end
			2'd2: begin cos_out <= -xs[N]; sin_out <= -ys[N]; end
			2'd3: begin cos_out <= ys[N]; sin_out <= -xs[N]; end
			default: begin cos_out <= xs[N]; sin_out <= ys[N]; end
		endcase
	end
endmodule

// ===== tb/tb_uca_steering_vector_generator.sv =====
// Self-checking testbench for the circular-array steering vector generator.
// Depends on ucasv_pkg and uca_steering_vector_generator directly; the CORDIC files come in through the latter.
`timescale 1ns / 100ps

module tb_uca_steering_vector_generator;

	// One steering element as it should leave the block.
	typedef struct {
		logic [3:0]         ch;
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic               lst;
	} phasor_t;

	// Arctangent of 2^-i in units of 2^-32 turn, for the CORDIC predictor.
	localparam longint ATAN_TURNS [28] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
	};
	localparam logic [31:0] ANGLE_MASK = 32'hFFFF_0000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [15:0] azimuth = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = ucasv_pkg::REG_NUM_CHANNELS;
	logic [15:0] cfg_data = '0;
	logic        strobe;
	logic [3:0]  channel;
	logic signed [15:0] phasor_re;
	logic signed [15:0] phasor_im;
	logic        last;

	// Azimuths waiting to be issued, and the phasors still owed by the block.
	logic [15:0] azimuth_q[$];
	phasor_t     phasor_q[$];

	// Our own copy of the two registers, tracked from accepted writes.
	logic [4:0]  count_reg = ucasv_pkg::RESET_CHANNELS;
	logic [15:0] radius_reg = ucasv_pkg::RESET_RADIUS;

	int  errors = 0;
	int  gap_left = 0;
	bit  steady = 1'b0;

	uca_steering_vector_generator i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .azimuth(azimuth),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .strobe(strobe), .channel(channel),
		.phasor_re(phasor_re), .phasor_im(phasor_im), .last(last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Generous ceiling: under two hundred items at up to sixteen words each with long gaps
	// come nowhere near this.
	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	// Cosine and sine of an angle in 2^-32 turn, both signed Q2.30.
	task automatic cordic_rotate(input logic [31:0] ang, output longint c, output longint s);
		longint x, y, z, dx, dy, t;
		begin
			x = 652032874;
			y = 0;
			z = longint'(ang[29:0]);
			for (int i = 0; i < 28; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= ATAN_TURNS[i];
				end else begin
					x += dx; y -= dy; z += ATAN_TURNS[i];
				end
			end
			case (ang[31:30])
				2'd1: begin t = x; x = -y; y = t; end
				2'd2: begin x = -x; y = -y; end
				2'd3: begin t = x; x = y; y = -t; end
				default: ;
			endcase
			c = x;
			s = y;
		end
	endtask

	// Rounds Q2.30 half up to Q1.15 and saturates.
	function automatic logic signed [15:0] q15_of(input longint v);
		longint r;
		begin
			r = (v + (64'sd1 <<< 14)) >>> 15;
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			return r[15:0];
		end
	endfunction

	// Works out the whole steering vector for one azimuth and queues it.
	task automatic queue_steering_vector(input logic [15:0] az);
		int          n;
		logic [31:0] theta, elem, diff, phase;
		logic [63:0] num;
		longint      c, s, proj;
		phasor_t     p;
		begin
			n = count_reg;
			if (n < 1) n = 1;
			if (n > 16) n = 16;
			theta = (ucasv_pkg::QUARTER_TURN - {az, 16'h0}) & ANGLE_MASK;
			p.ch = '0; p.re = 16'sd32767; p.im = '0; p.lst = (n == 1);
			phasor_q.push_back(p);
			for (int k = 1; k < n; k++) begin
				num = 64'(k - 1) << 32;
				elem = 32'(num / 64'(n - 1)) & ANGLE_MASK;
				diff = (theta - elem) & ANGLE_MASK;
				cordic_rotate(diff, c, s);
				proj = c * longint'(radius_reg);
				phase = 32'((proj + 512) >>> 10);
				phase = (phase + 32'h8000) & ANGLE_MASK;
				cordic_rotate(phase, c, s);
				p.ch = 4'(k); p.re = q15_of(c); p.im = q15_of(s); p.lst = (k == n - 1);
				phasor_q.push_back(p);
			end
		end
	endtask

	// Mostly short gaps, now and then a long one; none at all in steady phases.
	function automatic int pick_gap();
		if (steady) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
		return $urandom_range(5, 40);
	endfunction

	// Driver: a word is taken at an edge where start is high and busy low. The
	// slot is free when start is low or the current word has just been taken.
	always @(posedge clk) begin
		if (!start || !busy) begin
			if (start) queue_steering_vector(azimuth);
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (azimuth_q.size() > 0) begin
				start <= 1'b1;
				azimuth <= azimuth_q.pop_front();
				gap_left = pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobe carries one word, checked against the oldest phasor.
	always @(posedge clk) begin
		phasor_t e;
		if (arst_n && strobe) begin
			if (phasor_q.size() == 0) begin
				$display("%0t: unexpected word ch %0d re %0d im %0d last %0b", $time,
					channel, phasor_re, phasor_im, last);
				errors++;
			end else begin
				e = phasor_q.pop_front();
				if (channel !== e.ch || phasor_re !== e.re || phasor_im !== e.im ||
						last !== e.lst) begin
					$display("%0t: expected ch %0d re %0d im %0d last %0b", $time,
						e.ch, e.re, e.im, e.lst);
					$display("%0t: actual   ch %0d re %0d im %0d last %0b", $time,
						channel, phasor_re, phasor_im, last);
					errors++;
				end
			end
		end
	end

	// Waits until every azimuth has gone in and every word has come out, then
	// lets the pipeline drain a little further.
	task automatic wait_idle();
		begin
			do @(negedge clk); while (azimuth_q.size() != 0 || start || phasor_q.size() != 0);
			repeat (80) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] data);
		begin
			@(posedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= data;
			do @(posedge clk); while (!cfg_ready);
			cfg_valid <= 1'b0;
			if (idx == ucasv_pkg::REG_NUM_CHANNELS) count_reg = data[4:0];
			else radius_reg = data;
		end
	endtask

	task automatic random_phase(input int items);
		begin
			for (int i = 0; i < items; i++) azimuth_q.push_back(16'($urandom_range(0, 65535)));
			wait_idle();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset setting: the compass points, both ends of the
		// field and alternating bit patterns.
		azimuth_q = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h0001,
			16'h5555, 16'hAAAA, 16'h7FFF, 16'h2000};
		wait_idle();

		// A single channel gives only the reference word; zero is read as one.
		write_reg(ucasv_pkg::REG_NUM_CHANNELS, 16'd1);
		azimuth_q = '{16'h0000, 16'h1234};
		wait_idle();
		write_reg(ucasv_pkg::REG_NUM_CHANNELS, 16'd0);
		azimuth_q = '{16'hFFFF};
		wait_idle();

		// Counts above the maximum saturate; zero and full-scale radius.
		write_reg(ucasv_pkg::REG_NUM_CHANNELS, 16'd31);
		write_reg(ucasv_pkg::REG_RING_RADIUS, 16'hFFFF);
		azimuth_q = '{16'h0000, 16'hFFFF, 16'h6000};
		wait_idle();
		write_reg(ucasv_pkg::REG_RING_RADIUS, 16'h0000);
		azimuth_q = '{16'h0000, 16'h9000};
		wait_idle();

		// Random part across several settings; upper data bits must be ignored.
		write_reg(ucasv_pkg::REG_NUM_CHANNELS, 16'hFFE3);
		write_reg(ucasv_pkg::REG_RING_RADIUS, 16'd1352);
		random_phase(25);
		write_reg(ucasv_pkg::REG_NUM_CHANNELS, 16'd16);
		write_reg(ucasv_pkg::REG_RING_RADIUS, 16'hFFFF);
		steady = 1'b1;
		random_phase(25);
		steady = 1'b0;
		write_reg(ucasv_pkg::REG_NUM_CHANNELS, 16'd2);
		write_reg(ucasv_pkg::REG_RING_RADIUS, 16'd4096);
		random_phase(25);
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(ucasv_pkg::REG_NUM_CHANNELS, 16'($urandom_range(0, 65535)));
			write_reg(ucasv_pkg::REG_RING_RADIUS, 16'($urandom_range(0, 65535)));
			steady = (ph == 2);
			random_phase(15);
		end
		steady = 1'b0;
		write_reg(ucasv_pkg::REG_NUM_CHANNELS, 16'd9);
		write_reg(ucasv_pkg::REG_RING_RADIUS, 16'd1352);
		random_phase(10);

		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/ucasv_pkg.sv
hw/rtl/ucasv_cordic_cell.sv
hw/rtl/ucasv_cordic.sv
hw/rtl/uca_steering_vector_generator.sv
tb/tb_uca_steering_vector_generator.sv
